@@ rtl/core/stpr_pkg.sv @@
package stpr_pkg;

    // Default build values
    localparam int MEM_ADDR_BITS_DEF = 16;
    localparam int PALETTE_BASE_DEF  = 61440;
    localparam int TILE_BASE_DEF     = 0;

    // Wide enough for every address sum before it wraps to the memory size
    localparam int SUM_W = 21;

    // Stream word widths
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 48;

    // Input word field offsets (tdata)
    localparam int F_WADDR = 0;
    localparam int F_WBYTE = 16;
    localparam int F_SX    = 24;
    localparam int F_SY    = 32;
    localparam int F_WT    = 40;
    localparam int F_FLAGS = 48;
    localparam int F_MODE  = 56;
    localparam int F_COLS  = 64;
    localparam int F_MAP   = 80;
    localparam int F_ROW   = 96;
    localparam int F_COL   = 109;

    // Operation codes carried in tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CLIP_LEFT   = 2'd0,
        CFG_CLIP_TOP    = 2'd1,
        CFG_CLIP_SPAN_X = 2'd2,
        CFG_CLIP_SPAN_Y = 2'd3
    } t_cfg_idx;

    // Tile map modes
    localparam logic [1:0] MAP_INV_BIT = 2'd1;
    localparam logic [1:0] MAP_XOR2    = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAP,
        ST_MAP_RD,
        ST_TILE,
        ST_TILE_RD,
        ST_PIX,
        ST_PAL,
        ST_PAL_END,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch the accepted word, store byte on a write
        logic div;        // unscale offsets, clip check
        logic map_addr;   // form tile map address
        logic tile_addr;  // decode map byte, form tile byte address
        logic pix;        // pick pixel, form palette address
        logic pal_step;   // advance palette byte address
        logic pal_shift;  // shift read byte into the color word
        logic out_load;   // load the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pass;    // sprite has width and pixel is inside the window
        logic opaque;  // fetched pixel is not masked out
    } t_dp_stat;

endpackage

@@ rtl/core/sprite_tile_pixel_renderer.sv @@
// Channel  | Dir | Handshake           | Word
// s        | in  | i_s_tvalid/tready   | tuser: operation; tdata: write item or render item
// m        | out | o_m_tvalid/tready   | tuser: pixel_write; tdata: pixel_x, pixel_y, color
// cfg      | in  | i_cfg_we            | i_cfg_idx register index, i_cfg_data 9-bit value
//
// One word at a time. A byte write is stored when accepted; a drawn pixel is unscaled,
// then reads map byte, tile byte and four palette bytes on the single byte port;
// zero-width or clipped pixels end after unscale, transparent ones after the tile read.
// Reset clears the controller and sets the clip window to 0,0 span 255,255;
// the byte memory is not cleared. The finished word waits in the output
// register; a stalled output only holds the engine in its last state.
module sprite_tile_pixel_renderer
    import stpr_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF,
    parameter int PALETTE_BASE  = PALETTE_BASE_DEF,
    parameter int TILE_BASE     = TILE_BASE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [15:0] write_address, [23:16] write_byte, [31:24] sprite_x,
    // [39:32] sprite_y, [47:40] map_width_tiles, [55:48] sprite_flags,
    // [63:56] sprite_mode, [79:64] sprite_colors, [95:80] map_address,
    // [108:96] row_offset, [121:109] col_offset, [127:122] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,   // [0] operation
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [7:0] pixel_x, [15:8] pixel_y, [47:16] pixel_color
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser,   // [0] pixel_write
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [8:0]            i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    stpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stpr_dp #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS),
        .PALETTE_BASE  (PALETTE_BASE),
        .TILE_BASE     (TILE_BASE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

@@ rtl/core/stpr_dp.sv @@
module stpr_dp
    import stpr_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF,
    parameter int PALETTE_BASE  = PALETTE_BASE_DEF,
    parameter int TILE_BASE     = TILE_BASE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [8:0]            i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser
);

    localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;
    localparam logic [16:0] RECIP3 = 17'd43691;  // ceil(2^17 / 3)

    // Offset divided by a scale of 1 to 4
    function automatic logic [12:0] unscale(input logic [12:0] v, input logic [1:0] sc);
        logic [29:0] prod;
        logic [12:0] res;
        prod = 30'(v) * 30'(RECIP3);
        unique case (sc)
            2'd0: res = v;
            2'd1: res = {1'b0, v[12:1]};
            2'd2: res = prod[29:17];
            default: res = {2'b00, v[12:2]};
        endcase
        return res;
    endfunction

    // Clip window registers
    logic [8:0] r_clip_left, r_clip_top, r_span_x, r_span_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left <= 9'd0;
            r_clip_top  <= 9'd0;
            r_span_x    <= 9'd255;
            r_span_y    <= 9'd255;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CLIP_LEFT:   r_clip_left <= i_cfg_data;
                CFG_CLIP_TOP:    r_clip_top  <= i_cfg_data;
                CFG_CLIP_SPAN_X: r_span_x    <= i_cfg_data;
                CFG_CLIP_SPAN_Y: r_span_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latched item fields
    logic [7:0]  r_sx, r_sy, r_wt, r_flags, r_mode;
    logic [15:0] r_cols, r_map;
    logic [12:0] r_row, r_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx    <= i_s_tdata[F_SX +: 8];
            r_sy    <= i_s_tdata[F_SY +: 8];
            r_wt    <= i_s_tdata[F_WT +: 8];
            r_flags <= i_s_tdata[F_FLAGS +: 8];
            r_mode  <= i_s_tdata[F_MODE +: 8];
            r_cols  <= i_s_tdata[F_COLS +: 16];
            r_map   <= i_s_tdata[F_MAP +: 16];
            r_row   <= i_s_tdata[F_ROW +: 13];
            r_col   <= i_s_tdata[F_COL +: 13];
        end
    end

    // Byte memory: one write port, one registered read port
    logic [7:0]               r_mem [MEM_DEPTH];
    logic [MEM_ADDR_BITS-1:0] r_addr;
    logic [7:0]               r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_s_tuser == OP_WRITE)
            r_mem[MEM_ADDR_BITS'(i_s_tdata[F_WADDR +: 16])] <= i_s_tdata[F_WBYTE +: 8];
        r_rdata <= r_mem[r_addr];
    end

    // Screen position and clip test on unwrapped sums
    logic [13:0] pos_x, pos_y;
    logic [9:0]  lim_x, lim_y;
    logic        clip_ok;

    always_comb begin
        pos_x   = 14'(r_sx) + 14'(r_col);
        pos_y   = 14'(r_sy) + 14'(r_row);
        lim_x   = 10'(r_clip_left) + 10'(r_span_x);
        lim_y   = 10'(r_clip_top) + 10'(r_span_y);
        clip_ok = (pos_x >= 14'(r_clip_left)) && (pos_x <= 14'(lim_x)) &&
                  (pos_y >= 14'(r_clip_top))  && (pos_y <= 14'(lim_y));
    end

    // Unscaled offsets
    logic [12:0] r_sub_r, r_sub_c;
    logic [7:0]  r_px_x, r_px_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div) begin
            r_sub_r <= unscale(r_row, r_flags[7:6]);
            r_sub_c <= unscale(r_col, r_flags[5:4]);
            r_px_x  <= pos_x[7:0];
            r_px_y  <= pos_y[7:0];
        end
    end

    // Tile map byte address
    logic [17:0]      map_prod;
    logic [SUM_W-1:0] map_sum;

    always_comb begin
        map_prod = 18'(r_sub_r[12:3]) * 18'(r_wt);
        map_sum  = SUM_W'(r_map) + SUM_W'(map_prod) + SUM_W'(r_sub_c[12:3]);
    end

    // Map byte decode and tile byte address
    logic [7:0]       tile_num;
    logic [1:0]       tile_mask;
    logic [SUM_W-1:0] tile_sum;
    logic [1:0]       r_cmask;

    always_comb begin
        unique case (r_mode[1:0])
            MAP_INV_BIT: begin
                tile_mask = {1'b0, r_rdata[7]};
                tile_num  = {1'b0, r_rdata[6:0]};
            end
            MAP_XOR2: begin
                tile_mask = r_rdata[7:6];
                tile_num  = {2'b00, r_rdata[5:0]};
            end
            default: begin
                tile_mask = 2'd0;
                tile_num  = r_rdata;
            end
        endcase
        tile_sum = SUM_W'(TILE_BASE) + SUM_W'({r_mode[7:2], 12'd0}) +
                   SUM_W'({tile_num[7:3], 7'd0}) + SUM_W'({r_sub_r[2:0], 4'd0}) +
                   SUM_W'({tile_num[2:0], 1'b0}) + SUM_W'(r_sub_c[2]);
    end

    // Pixel pick, transparency and palette address
    logic [1:0]       pix_val;
    logic [1:0]       col_sel;
    logic [3:0]       cidx;
    logic [SUM_W-1:0] pal_sum;

    always_comb begin
        unique case (r_sub_c[1:0])
            2'd0: pix_val = r_rdata[7:6];
            2'd1: pix_val = r_rdata[5:4];
            2'd2: pix_val = r_rdata[3:2];
            default: pix_val = r_rdata[1:0];
        endcase
        col_sel = pix_val ^ r_cmask;
        unique case (col_sel)
            2'd0: cidx = r_cols[3:0];
            2'd1: cidx = r_cols[7:4];
            2'd2: cidx = r_cols[11:8];
            default: cidx = r_cols[15:12];
        endcase
        pal_sum = SUM_W'(PALETTE_BASE) + SUM_W'({cidx, 2'b00});
    end

    assign o_stat.pass   = (r_wt != 8'd0) && clip_ok;
    assign o_stat.opaque = !r_flags[pix_val];

    // Address register and draw flag
    logic r_draw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_addr)
            r_addr <= map_sum[MEM_ADDR_BITS-1:0];
        else if (i_cmd.tile_addr)
            r_addr <= tile_sum[MEM_ADDR_BITS-1:0];
        else if (i_cmd.pix)
            r_addr <= pal_sum[MEM_ADDR_BITS-1:0];
        else if (i_cmd.pal_step)
            r_addr <= r_addr + {{(MEM_ADDR_BITS-1){1'b0}}, 1'b1};
        if (i_cmd.tile_addr)
            r_cmask <= tile_mask;
        if (i_cmd.load)
            r_draw <= 1'b0;
        else if (i_cmd.div)
            r_draw <= o_stat.pass;
        else if (i_cmd.pix)
            r_draw <= r_draw && o_stat.opaque;
    end

    // Palette word, low byte first
    logic [31:0] r_color;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_shift)
            r_color <= {r_rdata, r_color[31:8]};
    end

    // Output register
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_user;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_user <= r_draw;
            r_out_data <= r_draw ? {r_color, r_px_y, r_px_x} : '0;
        end
    end

    assign o_m_tdata = r_out_data;
    assign o_m_tuser = r_out_user;

endmodule

@@ rtl/core/stpr_ctrl.sv @@
module stpr_ctrl
    import stpr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  logic     i_s_tuser,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    // State, palette byte count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_s_tuser == OP_RENDER) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_state = i_stat.pass ? ST_MAP : ST_DONE;
            end
            ST_MAP: begin
                o_cmd.map_addr = 1'b1;
                n_state = ST_MAP_RD;
            end
            ST_MAP_RD: n_state = ST_TILE;
            ST_TILE: begin
                o_cmd.tile_addr = 1'b1;
                n_state = ST_TILE_RD;
            end
            ST_TILE_RD: n_state = ST_PIX;
            ST_PIX: begin
                o_cmd.pix = 1'b1;
                n_cnt = 2'd0;
                n_state = i_stat.opaque ? ST_PAL : ST_DONE;
            end
            ST_PAL: begin
                o_cmd.pal_step  = 1'b1;
                o_cmd.pal_shift = (r_cnt != 2'd0);
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3)
                    n_state = ST_PAL_END;
            end
            ST_PAL_END: begin
                o_cmd.pal_shift = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output word held until taken
    always_comb begin
        if (o_cmd.out_load)
            n_out_valid = 1'b1;
        else if (i_m_tready)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    assign o_m_tvalid = r_out_valid;

    // Checks
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != ST_IDLE))
        else $error("accepted word did not start work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("output word overwritten before taken");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_m_tvalid)
        else $error("loaded result not presented");

    a_four_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAL_END) |-> ($past(r_state) == ST_PAL && $past(r_cnt) == 2'd3))
        else $error("palette word not fetched in four reads");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div || o_cmd.pix || o_cmd.pal_step) |-> !o_s_tready)
        else $error("input taken while a pixel is in progress");

endmodule

@@ tb/sprite_tile_pixel_renderer_chk.sv @@
// Watches the input, output and register ports of the pixel renderer, keeps
// its own image of the byte memory and the clip window, and predicts each
// result word as the matching input word is accepted.
module sprite_tile_pixel_renderer_chk
    import stpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tuser,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [8:0]            i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int unsigned ADDR_MASK  = (1 << MEM_ADDR_BITS_DEF) - 1;
    localparam int          PRINT_CAP  = 100;

    typedef struct packed {
        logic        draw;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] color;
    } t_pixel;

    logic [7:0]  mem_image [0:(1 << MEM_ADDR_BITS_DEF) - 1];
    int unsigned clip_left, clip_top, clip_span_x, clip_span_y;
    t_pixel      expected_pixels [$];

    function automatic int unsigned mem_byte(input int unsigned addr);
        return 32'(mem_image[addr & ADDR_MASK]);
    endfunction

    // Expected framebuffer write for one render word
    function automatic t_pixel render_pixel(input logic [IN_DATA_W-1:0] w);
        logic [7:0]  flags, mode;
        int unsigned wt, row, col, r, c, scx, scy, tile, xmask;
        int unsigned sub_c, sub_r, px, idx, base;
        t_pixel      res;
        res   = '0;
        flags = w[F_FLAGS +: 8];
        mode  = w[F_MODE +: 8];
        wt    = 32'(w[F_WT +: 8]);
        row   = 32'(w[F_ROW +: 13]);
        col   = 32'(w[F_COL +: 13]);
        r     = 32'(w[F_SY +: 8]) + row;
        c     = 32'(w[F_SX +: 8]) + col;
        if (wt == 0) return res;
        if (r < clip_top || r > clip_top + clip_span_y) return res;
        if (c < clip_left || c > clip_left + clip_span_x) return res;

        // unscale and fetch the tile index from the map
        scx  = 32'(flags[5:4]) + 1;
        scy  = 32'(flags[7:6]) + 1;
        tile = mem_byte(32'(w[F_MAP +: 16]) + (row / (8 * scy)) * wt + col / (8 * scx));
        xmask = 0;
        if (mode[1:0] == MAP_INV_BIT) begin
            xmask = (tile >> 7) & 1;
            tile  = tile & 'h7F;
        end else if (mode[1:0] == MAP_XOR2) begin
            xmask = (tile >> 6) & 3;
            tile  = tile & 'h3F;
        end

        // 2-bit pixel from the tile bank
        sub_c = col / scx;
        sub_r = row / scy;
        px = mem_byte(TILE_BASE_DEF + (32'(mode) & 32'hFC) * 1024 + (tile / 8) * 128
                      + (sub_r % 8) * 16 + (tile % 8) * 2 + 32'((sub_c % 8) >= 4));
        px = (px >> ((3 - sub_c % 4) * 2)) & 3;
        if (flags[px]) return res;

        // palette word, little endian
        idx  = (32'(w[F_COLS +: 16]) >> ((px ^ xmask) * 4)) & 'hF;
        base = PALETTE_BASE_DEF + 4 * idx;
        res.draw  = 1'b1;
        res.x     = c[7:0];
        res.y     = r[7:0];
        res.color = {8'(mem_byte(base + 3)), 8'(mem_byte(base + 2)),
                     8'(mem_byte(base + 1)), 8'(mem_byte(base))};
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < PRINT_CAP)
            $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_pixel got, want;
        if (!i_rst_n) begin
            clip_left    = 0;
            clip_top     = 0;
            clip_span_x  = 255;
            clip_span_y  = 255;
            expected_pixels.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            // output word: compare with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tuser, i_m_tdata[7:0], i_m_tdata[15:8], i_m_tdata[47:16]};
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected word", got.color, '0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.draw !== want.draw)
                        report_mismatch("pixel_write", 32'(got.draw), 32'(want.draw));
                    if (got.x !== want.x)
                        report_mismatch("pixel_x", 32'(got.x), 32'(want.x));
                    if (got.y !== want.y)
                        report_mismatch("pixel_y", 32'(got.y), 32'(want.y));
                    if (got.color !== want.color)
                        report_mismatch("pixel_color", got.color, want.color);
                end
            end

            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLIP_LEFT:   clip_left   = 32'(i_cfg_data);
                    CFG_CLIP_TOP:    clip_top    = 32'(i_cfg_data);
                    CFG_CLIP_SPAN_X: clip_span_x = 32'(i_cfg_data);
                    CFG_CLIP_SPAN_Y: clip_span_y = 32'(i_cfg_data);
                    default: ;
                endcase
            end

            // input word: store a byte or predict a pixel
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_WRITE) begin
                    mem_image[32'(i_s_tdata[F_WADDR +: 16]) & ADDR_MASK] =
                        i_s_tdata[F_WBYTE +: 8];
                    expected_pixels.push_back('0);
                end else begin
                    expected_pixels.push_back(render_pixel(i_s_tdata));
                end
            end
            o_pending = expected_pixels.size();
        end
    end

endmodule

@@ tb/sprite_tile_pixel_renderer_tb.sv @@
// Stimulus and verdict for the sprite pixel renderer. Render words are
// preceded by the byte writes their read path needs, so no byte is read
// before it has been written.
module sprite_tile_pixel_renderer_tb;
    import stpr_pkg::*;

    localparam int unsigned ADDR_MASK    = (1 << MEM_ADDR_BITS_DEF) - 1;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_WORDS  = 235;
    localparam int          NUM_PHASES   = 8;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_idx;
    logic [8:0]            i_cfg_data;

    int         fail_count;
    int         pending;
    t_idle_mode idle_mode = IDLE_NONE;
    int         hold_req  = 0;
    int         hold_done = 0;
    int         words_sent = 0;
    int         quiet_cycles = 0;

    // what the stimulus has put in memory, and the clip window it set
    logic [7:0]  shadow  [0:(1 << MEM_ADDR_BITS_DEF) - 1];
    bit          written [0:(1 << MEM_ADDR_BITS_DEF) - 1];
    int unsigned clip_l = 0, clip_t = 0, span_x = 255, span_y = 255;

    always #2 i_clk = ~i_clk;

    sprite_tile_pixel_renderer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    sprite_tile_pixel_renderer_chk u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: cycles without any accepted word or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done++;
            end else if (idle_mode == IDLE_RECEIVER) begin
                i_m_tready <= ($urandom_range(99) >= 79);
            end else if (idle_mode == IDLE_BOTH) begin
                i_m_tready <= ($urandom_range(99) >= 16);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic bit send_gap();
        if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 79;
        if (idle_mode == IDLE_BOTH)   return $urandom_range(99) < 16;
        return 1'b0;
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_word();
        logic [IN_DATA_W-1:0] w;
        w = {$urandom, $urandom, $urandom, $urandom};
        w[IN_DATA_W-1:F_COL+13] = '0;
        return w;
    endfunction

    // First byte on the read path of a render word that was never written,
    // or -1 when every byte it reads is known.
    function automatic int missing_byte(input logic [IN_DATA_W-1:0] w);
        logic [7:0]  flags, mode;
        int unsigned wt, row, col, r, c, scx, scy, a, t, xmask, sub_c, sub_r, px, idx, k;
        flags = w[F_FLAGS +: 8];
        mode  = w[F_MODE +: 8];
        wt    = 32'(w[F_WT +: 8]);
        row   = 32'(w[F_ROW +: 13]);
        col   = 32'(w[F_COL +: 13]);
        r     = 32'(w[F_SY +: 8]) + row;
        c     = 32'(w[F_SX +: 8]) + col;
        if (wt == 0 || r < clip_t || r > clip_t + span_y || c < clip_l || c > clip_l + span_x)
            return -1;
        scx = 32'(flags[5:4]) + 1;
        scy = 32'(flags[7:6]) + 1;
        a = (32'(w[F_MAP +: 16]) + (row / (8 * scy)) * wt + col / (8 * scx)) & ADDR_MASK;
        if (!written[a]) return int'(a);
        t = 32'(shadow[a]);
        xmask = 0;
        if (mode[1:0] == MAP_INV_BIT) begin
            xmask = t >> 7;
            t     = t & 'h7F;
        end else if (mode[1:0] == MAP_XOR2) begin
            xmask = t >> 6;
            t     = t & 'h3F;
        end
        sub_c = col / scx;
        sub_r = row / scy;
        a = (TILE_BASE_DEF + (32'(mode) & 32'hFC) * 1024 + (t / 8) * 128 + (sub_r % 8) * 16
             + (t % 8) * 2 + 32'((sub_c % 8) >= 4)) & ADDR_MASK;
        if (!written[a]) return int'(a);
        px = (32'(shadow[a]) >> ((3 - sub_c % 4) * 2)) & 3;
        if (flags[px]) return -1;
        idx = (32'(w[F_COLS +: 16]) >> ((px ^ xmask) * 4)) & 'hF;
        for (k = 0; k < 4; k++) begin
            a = (PALETTE_BASE_DEF + 4 * idx + k) & ADDR_MASK;
            if (!written[a]) return int'(a);
        end
        return -1;
    endfunction

    // One word on the input channel; called and left at a falling edge
    task automatic push_word(input logic op, input logic [IN_DATA_W-1:0] w);
        while (send_gap()) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_write(input logic [15:0] addr, input logic [7:0] value);
        logic [IN_DATA_W-1:0] w;
        w = rand_word();
        w[F_WADDR +: 16] = addr;
        w[F_WBYTE +: 8]  = value;
        shadow[32'(addr) & ADDR_MASK]  = value;
        written[32'(addr) & ADDR_MASK] = 1'b1;
        push_word(OP_WRITE, w);
    endtask

    // fill in whatever the pixel reads, then render it
    task automatic send_render(input logic [IN_DATA_W-1:0] w);
        int a;
        a = missing_byte(w);
        while (a >= 0) begin
            send_write(a[15:0], 8'($urandom_range(255)));
            a = missing_byte(w);
        end
        push_word(OP_RENDER, w);
    endtask

    function automatic logic [IN_DATA_W-1:0] render_word(
        input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] wt,
        input logic [7:0] flags, input logic [7:0] mode, input logic [15:0] colors,
        input logic [15:0] map, input logic [12:0] row, input logic [12:0] col);
        logic [IN_DATA_W-1:0] w;
        w = rand_word();
        w[F_SX +: 8]     = sx;
        w[F_SY +: 8]     = sy;
        w[F_WT +: 8]     = wt;
        w[F_FLAGS +: 8]  = flags;
        w[F_MODE +: 8]   = mode;
        w[F_COLS +: 16]  = colors;
        w[F_MAP +: 16]   = map;
        w[F_ROW +: 13]   = row;
        w[F_COL +: 13]   = col;
        return w;
    endfunction

    function automatic logic [12:0] pick_offset();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return 13'($urandom_range(63));
        if (r < 90) return 13'($urandom_range(1023));
        return 13'($urandom_range(8191));
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_render();
        logic [7:0]  wt, flags;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6)       wt = 8'd0;
        else if (r < 85) wt = 8'($urandom_range(1, 8));
        else             wt = 8'($urandom_range(1, 255));
        flags = 8'($urandom_range(255));
        if ($urandom_range(1)) flags[3:0] = 4'h0;
        return render_word(8'($urandom_range(255)), 8'($urandom_range(255)), wt, flags,
                           8'($urandom_range(255)), 16'($urandom_range(65535)),
                           16'($urandom_range(65535)), pick_offset(), pick_offset());
    endfunction

    // mostly renders, some stray writes and palette rewrites
    task automatic random_step();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            send_write(16'($urandom_range(65535)), 8'($urandom_range(255)));
        else if (r < 15)
            send_write(16'(PALETTE_BASE_DEF + $urandom_range(63)), 8'($urandom_range(255)));
        else
            send_render(random_render());
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_word(input t_cfg_idx idx, input logic [8:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
    endtask

    task automatic set_clip(input logic [8:0] l, input logic [8:0] t,
                            input logic [8:0] wx, input logic [8:0] wy);
        cfg_word(CFG_CLIP_LEFT, l);
        cfg_word(CFG_CLIP_TOP, t);
        cfg_word(CFG_CLIP_SPAN_X, wx);
        cfg_word(CFG_CLIP_SPAN_Y, wy);
        i_cfg_we <= 1'b0;
        clip_l = 32'(l);
        clip_t = 32'(t);
        span_x = 32'(wx);
        span_y = 32'(wy);
    endtask

    initial begin
        int phase_end;
        bit held;
        bit paused;
        held       = 1'b0;
        paused     = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_WRITE;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_CLIP_LEFT;
        i_cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: address extremes, zero width, clipped, transparent,
        // each map mode, largest scale, wrapped map and tile addresses
        send_write(16'h0000, 8'h00);
        send_write(16'hFFFF, 8'hFF);
        send_render(render_word(8'h10, 8'h10, 8'd0, 8'h00, 8'h00, 16'hFFFF,
                                16'h0000, 13'd0, 13'd0));
        send_render(render_word(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'h1234,
                                16'h0000, 13'd8191, 13'd8191));
        send_render(render_word(8'h20, 8'h30, 8'd2, 8'h0F, 8'h00, 16'h5678,
                                16'h0000, 13'd3, 13'd5));
        send_render(render_word(8'h00, 8'h00, 8'd1, 8'h00, 8'h00, 16'hFFFF,
                                16'h0000, 13'd0, 13'd0));
        send_render(render_word(8'h40, 8'h08, 8'd4, 8'hF0, 8'h01, 16'h0000,
                                16'h8000, 13'd63, 13'd127));
        send_render(render_word(8'h7F, 8'h80, 8'd255, 8'h50, 8'hFE, 16'hA5C3,
                                16'hFFFF, 13'd255, 13'd200));
        send_render(render_word(8'hFF, 8'hFF, 8'd3, 8'hA0, 8'h03, 16'h3C5A,
                                16'h4321, 13'd0, 13'd0));
        send_render(render_word(8'h00, 8'h00, 8'd8, 8'h00, 8'h02, 16'h9E71,
                                16'h1000, 13'd255, 13'd255));

        // random phases: each sets a clip window and an idle pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0: set_clip(9'd0, 9'd0, 9'd255, 9'd255);
                1: set_clip(9'd0, 9'd0, 9'd511, 9'd511);
                3: set_clip(9'd511, 9'd511, 9'd511, 9'd511);
                4: set_clip(9'd0, 9'd0, 9'd0, 9'd0);
                6: set_clip(9'd0, 9'd0, 9'd511, 9'd511);
                default: set_clip(9'($urandom_range(200)), 9'($urandom_range(200)),
                                  9'($urandom_range(511)), 9'($urandom_range(511)));
            endcase
            idle_mode = t_idle_mode'(p % 4);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                random_step();
                // back-pressure, then a full pause on the sender side
                if (p == 0 && !held && words_sent >= phase_end - 180) begin
                    hold_req++;
                    held = 1'b1;
                end
                if (p == 0 && !paused && words_sent >= phase_end - 60) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        // wait for the last results, then a little longer
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sprite_tile_pixel_renderer.f @@
rtl/core/stpr_pkg.sv
rtl/core/stpr_dp.sv
rtl/core/stpr_ctrl.sv
rtl/core/sprite_tile_pixel_renderer.sv
tb/sprite_tile_pixel_renderer_chk.sv
tb/sprite_tile_pixel_renderer_tb.sv
